// ===== rtl/core/ptcm_pkg.sv =====
`default_nettype none

package ptcm_pkg;

   // Default values of the top-level parameters.
   localparam int MACRO_TIME_BITS_DEF = 48;
   localparam int WEIGHT_BITS_DEF     = 32;
   localparam int RSP_DEPTH_DEF       = 4;

   // Fixed field widths.
   localparam int MACRO_W  = 48;
   localparam int MICRO_W  = 16;
   localparam int TIME_W   = 64;
   localparam int WOUT_W   = 32;
   localparam int SHIFT_W  = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Configuration register indices.
   localparam logic [CSR_IDX_W-1:0] CSR_FINE_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MICRO_CHANNELS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COARSEN_SHIFT  = 2'd2;

   // Register reset values.
   localparam logic [MICRO_W-1:0] MICRO_CHANNELS_RST = 16'd1;
   localparam logic [SHIFT_W-1:0] COARSEN_SHIFT_RST  = 6'd1;

   // Control of one coarsened event handed from the time stage to the merge stage.
   typedef struct packed {
      logic valid;
      logic stream_end;
   } ptcm_evt_ctl_type;

   // One result entry as it is queued for the response channel.
   typedef struct packed {
      logic [TIME_W-1:0] time_val;
      logic [WOUT_W-1:0] weight;
      logic              entry_valid;
      logic              last;
   } ptcm_entry_type;

   // Results pushed by the merge stage in one cycle.
   typedef struct packed {
      logic [1:0]     count;
      ptcm_entry_type first;
      ptcm_entry_type second;
   } ptcm_push_type;

endpackage

`default_nettype wire

// ===== rtl/core/photon_time_coarsen_merge.sv =====
// A closing event passes the input and event registers; the merge stage then queues the result.
// Throughput: one event per cycle while the queue has room (two-stage pipeline, merge register).
// Each event may queue up to two results; the response queue holds RSP_DEPTH entries and
// events stall while fewer than two places are free.
// Reset: synchronous, active high; clears the pipeline, the pending entry, the queue and
// sets the configuration registers to their defaults.
`default_nettype none

module photon_time_coarsen_merge #(
   parameter int MACRO_TIME_BITS = ptcm_pkg::MACRO_TIME_BITS_DEF,
   parameter int WEIGHT_BITS     = ptcm_pkg::WEIGHT_BITS_DEF,
   parameter int RSP_DEPTH       = ptcm_pkg::RSP_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [ptcm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ptcm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [ptcm_pkg::MACRO_W-1:0]         req_macro_time,
   input  wire logic [ptcm_pkg::MICRO_W-1:0]         req_micro_time,
   input  wire logic signed [ptcm_pkg::WOUT_W-1:0]   req_weight_in,
   input  wire logic                                req_stream_end,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [ptcm_pkg::TIME_W-1:0]          rsp_time_out,
   output      logic signed [ptcm_pkg::WOUT_W-1:0]   rsp_weight_out,
   output      logic                                rsp_entry_valid,
   output      logic                                rsp_last_out
);

   logic                              fine_enable_ff, fine_enable_in;
   logic [ptcm_pkg::MICRO_W-1:0]      micro_channels_ff, micro_channels_in;
   logic [ptcm_pkg::SHIFT_W-1:0]      coarsen_shift_ff, coarsen_shift_in;
   ptcm_pkg::ptcm_evt_ctl_type        evt_ctl;
   logic                              evt_ready;
   logic [ptcm_pkg::TIME_W-1:0]       evt_time;
   logic signed [WEIGHT_BITS-1:0]     evt_weight;
   logic                              space_ok;
   ptcm_pkg::ptcm_push_type           push;
   ptcm_pkg::ptcm_entry_type          head;

   // Configuration register decode.
   always_comb begin
      fine_enable_in    = fine_enable_ff;
      micro_channels_in = micro_channels_ff;
      coarsen_shift_in  = coarsen_shift_ff;
      if (csr_write) begin
         unique case (csr_index)
            ptcm_pkg::CSR_FINE_ENABLE:    fine_enable_in    = csr_wdata[0];
            ptcm_pkg::CSR_MICRO_CHANNELS: micro_channels_in = csr_wdata;
            ptcm_pkg::CSR_COARSEN_SHIFT:  coarsen_shift_in  = csr_wdata[ptcm_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_enable_ff    <= 1'b0;
         micro_channels_ff <= ptcm_pkg::MICRO_CHANNELS_RST;
         coarsen_shift_ff  <= ptcm_pkg::COARSEN_SHIFT_RST;
      end else begin
         fine_enable_ff    <= fine_enable_in;
         micro_channels_ff <= micro_channels_in;
         coarsen_shift_ff  <= coarsen_shift_in;
      end
   end

   // Input register and time coarsening.
   ptcm_time_stage #(
      .MACRO_TIME_BITS (MACRO_TIME_BITS),
      .WEIGHT_BITS     (WEIGHT_BITS)
   ) u_time_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_macro_time (req_macro_time),
      .req_micro_time (req_micro_time),
      .req_weight_in  (req_weight_in),
      .req_stream_end (req_stream_end),
      .fine_enable    (fine_enable_ff),
      .micro_channels (micro_channels_ff),
      .coarsen_shift  (coarsen_shift_ff),
      .evt_ctl        (evt_ctl),
      .evt_ready      (evt_ready),
      .evt_time       (evt_time),
      .evt_weight     (evt_weight)
   );

   // Pending entry and result generation.
   ptcm_merge #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .evt_ctl    (evt_ctl),
      .evt_ready  (evt_ready),
      .evt_time   (evt_time),
      .evt_weight (evt_weight),
      .space_ok   (space_ok),
      .push       (push)
   );

   // Response queue.
   ptcm_rsp_fifo #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_time_out    = head.time_val;
   assign rsp_weight_out  = $signed(head.weight);
   assign rsp_entry_valid = head.entry_valid;
   assign rsp_last_out    = head.last;

endmodule

`default_nettype wire

// ===== rtl/core/ptcm_time_stage.sv =====
`default_nettype none

module ptcm_time_stage #(
   parameter int MACRO_TIME_BITS = ptcm_pkg::MACRO_TIME_BITS_DEF,
   parameter int WEIGHT_BITS     = ptcm_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [ptcm_pkg::MACRO_W-1:0]        req_macro_time,
   input  wire logic [ptcm_pkg::MICRO_W-1:0]        req_micro_time,
   input  wire logic signed [ptcm_pkg::WOUT_W-1:0]  req_weight_in,
   input  wire logic                               req_stream_end,
   input  wire logic                               fine_enable,
   input  wire logic [ptcm_pkg::MICRO_W-1:0]        micro_channels,
   input  wire logic [ptcm_pkg::SHIFT_W-1:0]        coarsen_shift,
   output      ptcm_pkg::ptcm_evt_ctl_type          evt_ctl,
   input  wire logic                               evt_ready,
   output      logic [ptcm_pkg::TIME_W-1:0]         evt_time,
   output      logic signed [WEIGHT_BITS-1:0]       evt_weight
);

   localparam int RAW_W  = (WEIGHT_BITS > ptcm_pkg::WOUT_W) ? WEIGHT_BITS : ptcm_pkg::WOUT_W;
   localparam int PROD_W = MACRO_TIME_BITS + ptcm_pkg::MICRO_W;

   logic                                in_valid_ff, in_valid_in;
   logic [MACRO_TIME_BITS-1:0]          in_macro_ff;
   logic [ptcm_pkg::MICRO_W-1:0]        in_micro_ff;
   logic signed [WEIGHT_BITS-1:0]       in_weight_ff;
   logic                                in_end_ff;
   logic                                evt_valid_ff, evt_valid_in;
   logic                                evt_end_ff;
   logic [ptcm_pkg::TIME_W-1:0]         evt_time_ff, evt_time_in;
   logic signed [WEIGHT_BITS-1:0]       evt_weight_ff;
   logic                                in_adv;
   logic                                req_take;
   logic [RAW_W-1:0]                    weight_raw;
   logic [PROD_W-1:0]                   prod;
   logic [ptcm_pkg::TIME_W-1:0]         raw_time;

   // Pipeline flow control: each stage moves when the one after it frees up.
   assign in_adv    = !evt_valid_ff || evt_ready;
   assign req_ready = !in_valid_ff || in_adv;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (in_adv ? 1'b0 : in_valid_ff);
   assign evt_valid_in = in_adv ? in_valid_ff : evt_valid_ff;

   // The weight field is taken as unsigned bits and re-signed at bit WEIGHT_BITS-1.
   assign weight_raw = RAW_W'($unsigned(req_weight_in));

   // Fine time, then the coarsening shift.
   assign prod     = in_macro_ff * micro_channels;
   assign raw_time = fine_enable
                   ? (ptcm_pkg::TIME_W'(prod) + ptcm_pkg::TIME_W'(in_micro_ff))
                   : ptcm_pkg::TIME_W'(in_macro_ff);
   assign evt_time_in = raw_time >> coarsen_shift;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         evt_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         evt_valid_ff <= evt_valid_in;
      end
   end

   // Input register, loaded on every input transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_macro_ff  <= req_macro_time[MACRO_TIME_BITS-1:0];
         in_micro_ff  <= req_micro_time;
         in_weight_ff <= $signed(weight_raw[WEIGHT_BITS-1:0]);
         in_end_ff    <= req_stream_end;
      end
   end

   // Event register holding the coarsened time.
   always_ff @(posedge clock) begin
      if (in_valid_ff && in_adv) begin
         evt_time_ff   <= evt_time_in;
         evt_weight_ff <= in_weight_ff;
         evt_end_ff    <= in_end_ff;
      end
   end

   assign evt_ctl.valid      = evt_valid_ff;
   assign evt_ctl.stream_end = evt_end_ff;
   assign evt_time           = evt_time_ff;
   assign evt_weight         = evt_weight_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ptcm_merge.sv =====
`default_nettype none

module ptcm_merge #(
   parameter int WEIGHT_BITS = ptcm_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ptcm_pkg::ptcm_evt_ctl_type     evt_ctl,
   output      logic                          evt_ready,
   input  wire logic [ptcm_pkg::TIME_W-1:0]    evt_time,
   input  wire logic signed [WEIGHT_BITS-1:0] evt_weight,
   input  wire logic                          space_ok,
   output      ptcm_pkg::ptcm_push_type        push
);

   localparam int RAW_W = (WEIGHT_BITS > ptcm_pkg::WOUT_W) ? WEIGHT_BITS : ptcm_pkg::WOUT_W;
   localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

   logic                            pend_valid_ff, pend_valid_in;
   logic [ptcm_pkg::TIME_W-1:0]     pend_time_ff, pend_time_in;
   logic signed [WEIGHT_BITS-1:0]   pend_weight_ff, pend_weight_in;
   logic                            take;
   logic                            match;
   logic signed [WEIGHT_BITS:0]     sum_wide;
   logic signed [WEIGHT_BITS-1:0]   sum_sat;
   logic [ptcm_pkg::TIME_W-1:0]     new_time;
   logic signed [WEIGHT_BITS-1:0]   new_weight;
   logic                            emit_old;
   logic                            emit_new;
   logic                            emit_empty;
   ptcm_pkg::ptcm_entry_type        ent_old, ent_new, ent_empty;

   // Clamp a weight to the signed 32-bit range of the output field.
   function automatic logic [ptcm_pkg::WOUT_W-1:0] clamp_out(
      input logic signed [WEIGHT_BITS-1:0] v
   );
      logic signed [RAW_W-1:0] e;
      logic signed [RAW_W-1:0] lim_hi;
      logic signed [RAW_W-1:0] lim_lo;
      logic [ptcm_pkg::WOUT_W-1:0] r;
      e      = RAW_W'(v);
      lim_hi = RAW_W'(32'sh7fff_ffff);
      lim_lo = RAW_W'(32'sh8000_0000);
      if (e > lim_hi) begin
         r = ptcm_pkg::WOUT_W'(lim_hi);
      end else if (e < lim_lo) begin
         r = ptcm_pkg::WOUT_W'(lim_lo);
      end else begin
         r = ptcm_pkg::WOUT_W'(e);
      end
      return r;
   endfunction

   // An event is processed only when the queue can take two results.
   assign evt_ready = space_ok;
   assign take      = evt_ctl.valid && space_ok;

   // Saturating sum of the pending weight and the new one.
   assign sum_wide = {pend_weight_ff[WEIGHT_BITS-1], pend_weight_ff}
                   + {evt_weight[WEIGHT_BITS-1], evt_weight};
   always_comb begin
      if (sum_wide[WEIGHT_BITS] != sum_wide[WEIGHT_BITS-1]) begin
         sum_sat = sum_wide[WEIGHT_BITS] ? W_MIN : W_MAX;
      end else begin
         sum_sat = sum_wide[WEIGHT_BITS-1:0];
      end
   end

   // Merge against the pending entry or close it.
   assign match      = pend_valid_ff && (pend_time_ff == evt_time);
   assign new_time   = match ? pend_time_ff : evt_time;
   assign new_weight = match ? sum_sat : evt_weight;

   assign emit_old   = !match && pend_valid_ff && (pend_weight_ff != '0);
   assign emit_new   = evt_ctl.stream_end && (new_weight != '0);
   assign emit_empty = evt_ctl.stream_end && !emit_old && !emit_new;

   // Result entries that this event may cause.
   always_comb begin
      ent_old.time_val    = pend_time_ff;
      ent_old.weight      = clamp_out(pend_weight_ff);
      ent_old.entry_valid = 1'b1;
      ent_old.last        = evt_ctl.stream_end && !emit_new;

      ent_new.time_val    = new_time;
      ent_new.weight      = clamp_out(new_weight);
      ent_new.entry_valid = 1'b1;
      ent_new.last        = 1'b1;

      ent_empty.time_val    = '0;
      ent_empty.weight      = '0;
      ent_empty.entry_valid = 1'b0;
      ent_empty.last        = 1'b1;
   end

   always_comb begin
      push.second = ent_new;
      if (emit_old) begin
         push.first = ent_old;
      end else if (emit_new) begin
         push.first = ent_new;
      end else begin
         push.first = ent_empty;
      end
      if (!take) begin
         push.count = 2'd0;
      end else begin
         push.count = 2'(emit_old) + 2'(emit_new) + 2'(emit_empty);
      end
   end

   // Pending entry update; the stream end leaves the state empty.
   assign pend_valid_in  = take ? !evt_ctl.stream_end : pend_valid_ff;
   assign pend_time_in   = take ? (evt_ctl.stream_end ? '0 : new_time) : pend_time_ff;
   assign pend_weight_in = take ? (evt_ctl.stream_end ? '0 : new_weight) : pend_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_time_ff   <= pend_time_in;
      pend_weight_ff <= pend_weight_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/ptcm_rsp_fifo.sv =====
`default_nettype none

module ptcm_rsp_fifo #(
   parameter int RSP_DEPTH = ptcm_pkg::RSP_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ptcm_pkg::ptcm_push_type     push,
   output      logic                       space_ok,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      ptcm_pkg::ptcm_entry_type    head
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RSP_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(RSP_DEPTH - 2);

   ptcm_pkg::ptcm_entry_type mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PTR_W-1:0]         wr_ptr_next;
   logic                     pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = (count_ff != '0);
   assign space_ok    = (count_ff <= CNT_ROOM);
   assign head        = mem_ff[rd_ptr_ff];
   assign wr_ptr_next = ptr_inc(wr_ptr_ff);

   // Pointer and fill count update.
   always_comb begin
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Up to two entries are written in one cycle.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire
